/* hdl/slec_pkg.sv */
`timescale 1ns / 1ps
// shared types for the sequential list engine: request and response items,
// function and status codes, sequencer states and the cell control group
// no dependencies
package slec_pkg;

   typedef enum logic [2:0] {
      FN_INSERT = 3'd0,
      FN_REMOVE = 3'd1,
      FN_SEARCH = 3'd2,
      FN_VISIT  = 3'd3,
      FN_CLEAR  = 3'd4
   } slec_func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } slec_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FIND
   } slec_state_type;

   typedef struct packed {
      slec_func_type      func;
      logic [6:0]         position;
      logic signed [31:0] item_value;
   } slec_req_type;

   typedef struct packed {
      slec_status_type    status;
      logic               found;
      logic [5:0]         found_position;
      logic signed [31:0] read_value;
      logic [6:0]         count;
   } slec_rsp_type;

   // per-cycle command broadcast along the row of cells
   typedef struct packed {
      logic ins;
      logic rem;
      logic cmp;
   } slec_cell_ctl_type;

endpackage

/* hdl/slec_cell.sv */
`timescale 1ns / 1ps
// one list slot: holds an entry, shifts it up or down with its neighbours
// and compares it against the search key; depends on slec_pkg
module slec_cell
   import slec_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int CMP_W      = 7,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  slec_cell_ctl_type     ctl,
   input  logic [CMP_W-1:0]      pos,
   input  logic [CMP_W-1:0]      count,
   input  logic [DATA_WIDTH-1:0] key,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  match
);

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  match_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (MY_IDX == pos) begin
            data_in = key;
         end else if (MY_IDX > pos) begin
            data_in = left_data;
         end
      end else if (ctl.rem && (MY_IDX >= pos)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctl.cmp) begin
         match_ff <= (data_ff == key) && (MY_IDX < count);
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

/* hdl/sequential_list_engine_core.sv */
`timescale 1ns / 1ps
// top level of the sequential list engine: request sequencer, row of list
// cells and first-match encoder; depends on slec_pkg and slec_cell
//
// A request is taken when start is high and busy is low, and its result is
// presented for exactly one cycle with rsp_valid high after the steps below.
// busy drops in that same cycle, so the next request can be taken while the
// last result is shown. The three steps are: the cell row shifts or compares
// in parallel, the per-cell match flags are encoded to the lowest matching
// position, then the result register is shown. The receiver cannot stall:
// a result not captured during its strobe cycle is gone. Entries are held
// one per cell, so insert and remove cost the same at any position.
module sequential_list_engine_core
   import slec_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  slec_req_type req_item,
   output logic         rsp_valid,
   output slec_rsp_type rsp_item
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   slec_state_type state_ff, state_in;

   slec_req_type    req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   slec_status_type status_ff, status_in;
   logic [31:0]     read_ff, read_in;
   logic            search_ff;
   logic            rsp_valid_ff;
   slec_rsp_type    rsp_ff;

   slec_cell_ctl_type     cell_ctl;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [DATA_WIDTH-1:0] key;
   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]   match_vec;
   logic                  ins_ok, rem_ok, visit_ok;

   logic [CAPACITY-1:0]   low_hot;
   logic [IDX_W-1:0]      hit_idx;

   assign pos_ext = CMP_W'(req_ff.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign key     = DATA_WIDTH'(req_ff.item_value);

   // request decode against the current length
   always_comb begin
      ins_ok    = 1'b0;
      rem_ok    = 1'b0;
      visit_ok  = 1'b0;
      status_in = ST_OK;
      count_in  = count_ff;
      case (req_ff.func)
         FN_INSERT: begin
            if (count_ff == CNT_FULL) begin
               status_in = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               ins_ok   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         FN_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               rem_ok   = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         FN_VISIT: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               visit_ok = 1'b1;
            end
         end
         FN_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      read_in = '0;
      if (visit_ok) begin
         read_in = 32'(cell_data[pos_ext[IDX_W-1:0]]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC:  state_in = S_FIND;
         S_FIND:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy     = 1'b1;
      cell_ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
         end
         S_EXEC: begin
            cell_ctl.ins = ins_ok;
            cell_ctl.rem = rem_ok;
            cell_ctl.cmp = (req_ff.func == FN_SEARCH);
         end
         S_FIND: begin
         end
         default: begin
         end
      endcase
   end

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_d, right_d;
         if (i == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_left
            assign left_d = cell_data[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
         end else begin : g_right
            assign right_d = cell_data[i+1];
         end
         slec_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .CMP_W     (CMP_W),
            .INDEX     (i)
         ) u_cell (
            .clock     (clock),
            .ctl       (cell_ctl),
            .pos       (pos_ext),
            .count     (cnt_ext),
            .key       (key),
            .left_data (left_d),
            .right_data(right_d),
            .data      (cell_data[i]),
            .match     (match_vec[i])
         );
      end
   endgenerate

   // isolate the lowest match flag, then encode its position
   assign low_hot = match_vec & (~match_vec + 1'b1);

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (low_hot[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_FIND);
         if (state_ff == S_EXEC) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && start) begin
         req_ff <= req_item;
      end
      if (state_ff == S_EXEC) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         search_ff <= (req_ff.func == FN_SEARCH);
      end
      if (state_ff == S_FIND) begin
         rsp_ff.status         <= status_ff;
         rsp_ff.found          <= search_ff && (|match_vec);
         rsp_ff.found_position <= (search_ff && (|match_vec)) ? 6'(hit_idx) : '0;
         rsp_ff.read_value     <= read_ff;
         rsp_ff.count          <= 7'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
